@@ rtl/stream_find_replace_unit_defines.svh @@
// Assertion macros shared by the checker of stream_find_replace_unit.
`ifndef STREAM_FIND_REPLACE_UNIT_DEFINES_SVH
`define STREAM_FIND_REPLACE_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sfr_pkg.sv @@
// Shared constants, register codes and types of the stream find-and-replace unit.
`timescale 1ns / 1ps
package sfr_pkg;

  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 4;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 2;
  localparam int BURST_MAX       = 8;
  localparam int MAX_PATTERN_DEF = 8;
  localparam int MAX_REPL_DEF    = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_PATTERN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LENGTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_TEXT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  // One group of result words produced by a single input word
  typedef struct packed {
    logic [BURST_MAX*BYTE_W-1:0] data;
    logic [LEN_W-1:0]            n;
    logic                        last;
    logic                        marker;
  } sfr_burst_t;

endpackage

@@ rtl/sfr_in_if.sv @@
// Input channel: one text byte per word with a last flag.
`timescale 1ns / 1ps
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

@@ rtl/sfr_out_if.sv @@
// Output channel: one rewritten byte per word, a presence flag and a last flag.
`timescale 1ns / 1ps
interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       out_last;

  modport source (output valid, output out_byte, output byte_present, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_present, input out_last,
                  output ready);
endinterface

@@ rtl/sfr_cell.sv @@
// One window cell: holds a text byte, passes it on, and compares the incoming byte.
`timescale 1ns / 1ps
module sfr_cell (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic [sfr_pkg::BYTE_W-1:0] d_in,
  input  logic [sfr_pkg::BYTE_W-1:0] pat,
  input  logic                      pat_used,
  output logic [sfr_pkg::BYTE_W-1:0] q,
  output logic                      hit
);
  import sfr_pkg::*;

  // Advance the byte toward the older end of the window
  always_ff @(posedge clk) begin
    if (shift_en) begin
      q <= d_in;
    end
  end

  // Compare the byte that enters this cell against its pattern byte
  assign hit = !pat_used || (d_in == pat);

endmodule

@@ rtl/sfr_burst.sv @@
// Result buffer: holds one input's words and hands out one per ready cycle.
`timescale 1ns / 1ps
module sfr_burst (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  sfr_pkg::sfr_burst_t load_data,
  output logic                load_ok,
  sfr_out_if.source           out_chan
);
  import sfr_pkg::*;

  logic [BURST_MAX*BYTE_W-1:0] data;
  logic [LEN_W-1:0]            remaining;
  logic                        last;
  logic                        marker;
  logic                        take;

  assign take    = out_chan.valid && out_chan.ready;
  assign load_ok = (remaining == '0) || ((remaining == LEN_W'(1)) && out_chan.ready);

  // Count of words still to deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load) begin
      remaining <= load_data.n;
    end else if (take) begin
      remaining <= remaining - LEN_W'(1);
    end
  end

  // Load a new group or drop the word just taken
  always_ff @(posedge clk) begin
    if (load) begin
      data   <= load_data.data;
      last   <= load_data.last;
      marker <= load_data.marker;
    end else if (take) begin
      data <= data >> BYTE_W;
    end
  end

  assign out_chan.valid        = (remaining != '0);
  assign out_chan.out_byte     = data[BYTE_W-1:0];
  assign out_chan.byte_present = !marker;
  assign out_chan.out_last     = last && (remaining == LEN_W'(1));

endmodule

@@ rtl/stream_find_replace_unit.sv @@
// Latency: a word accepted at one edge shows its first result word after that edge.
// Throughput: one result word per cycle while the output is ready, and one input word
//   per cycle while each yields at most one; more stall the input until the last is taken.
// Reset: rst clears the configuration registers, the held window count and the result buffer.
// A search_length write empties the held window.
`timescale 1ns / 1ps
module stream_find_replace_unit #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPL_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data,
  sfr_in_if.sink                           in_chan,
  sfr_out_if.source                        out_chan
);
  import sfr_pkg::*;

  localparam int CELL_IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [CFG_DATA_W-1:0] search_pattern;
  logic [LEN_W-1:0]      search_length;
  logic [CFG_DATA_W-1:0] replacement_text;
  logic [LEN_W-1:0]      replacement_length;
  logic [LEN_W-1:0]      held_count;

  logic [LEN_W-1:0]      plen;
  logic [LEN_W-1:0]      rlen;
  logic [LEN_W-1:0]      win_cnt;
  logic [LEN_W-1:0]      held_count_next;
  logic                  full;
  logic                  match;
  logic                  use_repl;
  logic                  accept;
  logic                  load_ok;
  sfr_burst_t            burst;

  logic [BYTE_W-1:0]      cell_d [MAX_PATTERN];
  logic [BYTE_W-1:0]      cell_q [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      search_pattern     <= '0;
      search_length      <= '0;
      replacement_text   <= '0;
      replacement_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEARCH_PATTERN:     search_pattern     <= cfg_data;
        REG_SEARCH_LENGTH:      search_length      <= cfg_data[LEN_W-1:0];
        REG_REPLACEMENT_TEXT:   replacement_text   <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[LEN_W-1:0];
        default:                search_pattern     <= search_pattern;
      endcase
    end
  end

  // Clamp the lengths to the supported sizes
  assign plen = (search_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : search_length;
  assign rlen = (replacement_length > LEN_W'(MAX_REPLACEMENT)) ?
                LEN_W'(MAX_REPLACEMENT) : replacement_length;

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = load_ok;

  // Chain of window cells, newest byte in cell zero
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [LEN_W-1:0]  pidx;
    logic [BYTE_W-1:0] pat;

    if (j == 0) begin : g_head
      assign cell_d[j] = in_chan.in_byte;
    end else begin : g_link
      assign cell_d[j] = cell_q[j-1];
    end

    // Cell j compares the byte that sits plen-1-j places from the oldest one
    assign pidx = plen - LEN_W'(j) - LEN_W'(1);
    assign pat  = search_pattern[pidx[2:0]*BYTE_W +: BYTE_W];

    sfr_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .d_in     (cell_d[j]),
      .pat      (pat),
      .pat_used (LEN_W'(j) < plen),
      .q        (cell_q[j]),
      .hit      (hit[j])
    );
  end

  assign match = &hit;

  // Window size once the new byte is in
  always_comb begin
    if ((plen == '0) || (held_count >= plen)) begin
      win_cnt = LEN_W'(1);
    end else begin
      win_cnt = held_count + LEN_W'(1);
    end
  end

  assign full     = (plen != '0) && (win_cnt == plen);
  assign use_repl = full && match;

  // Held count after this word
  always_comb begin
    priority if (in_chan.in_last || (plen == '0) || use_repl) begin
      held_count_next = '0;
    end else if (full) begin
      held_count_next = plen - LEN_W'(1);
    end else begin
      held_count_next = win_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (cfg_we && (cfg_index == REG_SEARCH_LENGTH)) begin
      held_count <= '0;
    end else if (accept) begin
      held_count <= held_count_next;
    end
  end

  // Build the result group: replacement text or window bytes, oldest first
  always_comb begin
    logic [LEN_W-1:0] widx;
    logic [LEN_W-1:0] n;

    widx = '0;
    burst.data = '0;
    for (int k = 0; k < BURST_MAX; k++) begin
      widx = win_cnt - LEN_W'(1) - LEN_W'(k);
      if (use_repl) begin
        burst.data[k*BYTE_W +: BYTE_W] = replacement_text[k*BYTE_W +: BYTE_W];
      end else if (LEN_W'(k) < win_cnt) begin
        burst.data[k*BYTE_W +: BYTE_W] = cell_d[widx[CELL_IW-1:0]];
      end
    end

    priority if (plen == '0) begin
      n = LEN_W'(1);
    end else if (use_repl) begin
      n = rlen;
    end else if (in_chan.in_last) begin
      n = win_cnt;
    end else if (full) begin
      n = LEN_W'(1);
    end else begin
      n = '0;
    end

    // An empty last group becomes a single marker word with a zero byte
    burst.last   = in_chan.in_last;
    burst.marker = (n == '0);
    burst.n      = (n == '0) ? LEN_W'(in_chan.in_last) : n;
    if (n == '0) begin
      burst.data = '0;
    end
  end

  sfr_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && (burst.n != '0)),
    .load_data (burst),
    .load_ok   (load_ok),
    .out_chan  (out_chan)
  );

endmodule

@@ rtl/sfr_checker.sv @@
// Port-level checker for stream_find_replace_unit and its bind.
`timescale 1ns / 1ps
`include "stream_find_replace_unit_defines.svh"
module sfr_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic byte_present,
  input logic out_last
);

  // Reset empties the result buffer
  `SFR_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result word after reset")

  // A word waiting on the output stays offered
  `SFR_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "result word withdrawn")

  // An empty end marker only closes a text
  `SFR_ASSERT(a_marker_last, (out_valid && !byte_present) |-> out_last, "marker without last")

  // With nothing pending the input is open
  `SFR_ASSERT(a_idle_ready, (!out_valid && !rst) |-> in_ready, "input stalled while idle")

endmodule

bind stream_find_replace_unit sfr_checker u_sfr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .byte_present (out_chan.byte_present),
  .out_last     (out_chan.out_last)
);

@@ tb/stream_find_replace_unit_test.sv @@
// Self-checking testbench of the stream find-and-replace unit.
`timescale 1ns / 1ps

import sfr_pkg::*;

// One word of rewritten text as the output channel carries it
typedef struct packed {
  logic [7:0] text_byte;
  logic       present;
  logic       last;
} text_word_t;

// Tracks the rewrite of the text and the words still due from the unit
class rewrite_board;
  logic [63:0]  pattern;
  logic [63:0]  repl;
  logic [3:0]   slen;
  logic [3:0]   rlen;
  logic [7:0]   held[8];
  int unsigned  held_cnt;
  text_word_t   due[$];
  int           mismatches;
  int           checked;
  int           markers;

  function new();
    pattern    = '0;
    repl       = '0;
    slen       = '0;
    rlen       = '0;
    held_cnt   = 0;
    mismatches = 0;
    checked    = 0;
    markers    = 0;
    foreach (held[i]) held[i] = '0;
  endfunction

  function int unsigned eff_search_len();
    return (slen > 4'd8) ? 8 : int'(slen);
  endfunction

  function int pending();
    return due.size();
  endfunction

  // Mirror a register write; a new search length empties the window
  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    case (idx)
      REG_SEARCH_PATTERN: pattern = data;
      REG_SEARCH_LENGTH: begin
        slen     = data[3:0];
        held_cnt = 0;
      end
      REG_REPLACEMENT_TEXT:   repl = data;
      REG_REPLACEMENT_LENGTH: rlen = data[3:0];
      default: ;
    endcase
  endfunction

  // Work out the words caused by one accepted text byte
  function void note_word(logic [7:0] b, logic l);
    text_word_t  burst[$];
    int unsigned plen;
    int unsigned n_repl;
    bit          hit;
    plen   = eff_search_len();
    n_repl = (rlen > 4'd8) ? 8 : int'(rlen);
    if (plen == 0) begin
      held_cnt = 0;
      burst.push_back('{text_byte: b, present: 1'b1, last: 1'b0});
    end else begin
      if (held_cnt >= plen) held_cnt = 0;
      held[held_cnt] = b;
      held_cnt++;
      if (held_cnt == plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++)
          if (held[i] != pattern[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          // Emit the replacement and clear the window
          for (int i = 0; i < n_repl; i++)
            burst.push_back('{text_byte: repl[8*i +: 8], present: 1'b1, last: 1'b0});
          held_cnt = 0;
        end else begin
          // Release the oldest byte and shift the window down
          burst.push_back('{text_byte: held[0], present: 1'b1, last: 1'b0});
          for (int i = 1; i < plen; i++) held[i-1] = held[i];
          held_cnt--;
        end
      end
      if (l) begin
        // Flush what is still held at the end of the text
        for (int i = 0; i < held_cnt && burst.size() < 8; i++)
          burst.push_back('{text_byte: held[i], present: 1'b1, last: 1'b0});
        held_cnt = 0;
      end
    end
    if (l) begin
      if (burst.size() == 0)
        burst.push_back('{text_byte: 8'h00, present: 1'b0, last: 1'b0});
      burst[burst.size()-1].last = 1'b1;
    end
    foreach (burst[i]) due.push_back(burst[i]);
  endfunction

  task report(string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH: %s", msg);
  endtask

  // Compare one output word against the oldest due word
  task check_word(logic [7:0] b, logic present, logic l);
    text_word_t want;
    if (due.size() == 0) begin
      report($sformatf("word with nothing due: byte=%02h present=%0b last=%0b", b, present, l));
      return;
    end
    want = due.pop_front();
    checked++;
    if (!want.present) markers++;
    if (b !== want.text_byte || present !== want.present || l !== want.last)
      report($sformatf("word %0d: got byte=%02h present=%0b last=%0b, want %02h %0b %0b",
                       checked, b, present, l, want.text_byte, want.present, want.last));
  endtask
endclass

module stream_find_replace_unit_test;

  localparam int WATCH_LIMIT  = 4000;
  localparam int SETTLE       = 4;
  localparam int RESET_CYCLES = 11;
  localparam int PHASES       = 8;
  localparam int DIRECTED     = 20;
  localparam int ITEMS        = 260;

  // Idle rates in percent per cycle
  localparam int IDLE_NONE = 0;
  localparam int IDLE_HIGH = 70;
  localparam int IDLE_BOTH = 20;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  sfr_in_if  in_if ();
  sfr_out_if out_if ();

  rewrite_board board;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           sent;
  int           settings;
  int           quiet;

  stream_find_replace_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Note accepted text bytes and watch for a stuck run
  always @(posedge clk) begin
    if (!rst && in_if.valid && in_if.ready) board.note_word(in_if.in_byte, in_if.in_last);
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= WATCH_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d words still due",
               quiet, board.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check output words and stall the output at random
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_if.valid && out_if.ready)
        board.check_word(out_if.out_byte, out_if.byte_present, out_if.out_last);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_word(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= l;
    do @(posedge clk); while (!in_if.ready);
    sent++;
  endtask

  // Hold the input until every due word has come out, then let the unit settle
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  // Write all four registers while the unit is idle; junk above the length bits
  task automatic apply_setting(input logic [63:0] pat, input logic [3:0] slen,
                               input logic [63:0] rep, input logic [3:0] rlen);
    logic [63:0] len_word;
    wait_drain();
    cfg_write(REG_SEARCH_PATTERN, pat);
    len_word = {$urandom, $urandom};
    len_word[3:0] = slen;
    cfg_write(REG_SEARCH_LENGTH, len_word);
    cfg_write(REG_REPLACEMENT_TEXT, rep);
    len_word = {$urandom, $urandom};
    len_word[3:0] = rlen;
    cfg_write(REG_REPLACEMENT_LENGTH, len_word);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Send one text mostly of whole and partial pattern copies; random with no pattern
  task automatic send_text(input bit close);
    logic [7:0]  text[$];
    int unsigned plen;
    int          len;
    int          kind;
    int          cut;
    int          pick;
    plen = board.eff_search_len();
    len  = $urandom_range(1, 12);
    while (text.size() < len) begin
      kind = $urandom_range(9);
      if (plen == 0 || kind >= 8) begin
        text.push_back(8'($urandom));
      end else if (kind < 4) begin
        for (int i = 0; i < plen; i++) text.push_back(board.pattern[8*i +: 8]);
      end else if (kind < 6) begin
        cut = $urandom_range(1, plen);
        for (int i = 0; i < cut; i++) text.push_back(board.pattern[8*i +: 8]);
      end else begin
        pick = $urandom_range(plen - 1);
        text.push_back(board.pattern[8*pick +: 8]);
      end
    end
    foreach (text[i]) send_word(text[i], close && (i == text.size() - 1));
  endtask

  initial begin
    logic [63:0] pat;
    logic [63:0] rep;
    logic [3:0]  slen;
    logic [3:0]  rlen;
    int          quota;
    board          = new();
    send_idle_pct  = IDLE_NONE;
    recv_stall_pct = IDLE_NONE;
    sent           = 0;
    settings       = 0;
    quiet          = 0;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    in_if.valid    <= 1'b0;
    in_if.in_byte  <= '0;
    in_if.in_last  <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pass-through after reset, byte extremes
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);

    // Pattern "abc" replaced by "XY"; "xabcab" ends with a flush of "ab"
    apply_setting(64'h0063_6261, 4'd3, 64'h5958, 4'd2);
    send_word(8'h78, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h63, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b1);

    // Leave "ab" held, then change the length mid-text to drop it
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b0);
    apply_setting(64'h6261, 4'd2, {$urandom, $urandom}, 4'd0);

    // Deleted match on the last byte gives an empty end marker
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b1);

    // Oversized lengths clamp to eight bytes each
    pat = 64'h00FF_00FF_00FF_00FF;
    apply_setting(pat, 4'd15, {$urandom, $urandom}, 4'd15);
    for (int i = 0; i < 8; i++) send_word(pat[8*i +: 8], i == 7);

    // Random phases, each with its own setting and idle mode
    for (int phase = 0; phase < PHASES; phase++) begin
      pat  = {$urandom, $urandom};
      rep  = {$urandom, $urandom};
      rlen = 4'($urandom_range(0, 15));
      case (phase)
        0: slen = 4'd0;
        1: begin
          slen = 4'd8;
          rlen = 4'd8;
        end
        2: begin
          slen = 4'd1;
          rlen = 4'd0;
        end
        3: begin
          slen = 4'd15;
          rlen = 4'd15;
        end
        4: slen = 4'd2;
        5: begin
          // Repeated byte makes overlapping candidates
          pat  = {8{8'($urandom)}};
          slen = 4'd3;
        end
        default: slen = 4'($urandom_range(1, 8));
      endcase
      apply_setting(pat, slen, rep, rlen);
      case (phase % 4)
        0: begin
          send_idle_pct  = IDLE_NONE;
          recv_stall_pct = IDLE_NONE;
        end
        1: begin
          send_idle_pct  = IDLE_HIGH;
          recv_stall_pct = IDLE_NONE;
        end
        2: begin
          send_idle_pct  = IDLE_NONE;
          recv_stall_pct = IDLE_HIGH;
        end
        default: begin
          send_idle_pct  = IDLE_BOTH;
          recv_stall_pct = IDLE_BOTH;
        end
      endcase
      quota = DIRECTED + (phase + 1) * (ITEMS - DIRECTED) / PHASES;
      while (sent < quota) begin
        send_text(1'b1);
        if ($urandom_range(5) == 0) wait_drain();
      end
      // Sometimes leave a text open for the next length write to discard
      if ($urandom_range(2) == 0) send_text(1'b0);
    end

    wait_drain();
    repeat (10 * SETTLE) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d words never came out", board.pending()));

    $display("Sent %0d text bytes under %0d register settings with four idle modes;",
             sent, settings);
    $display("checked %0d output words, %0d of them empty end markers.",
             board.checked, board.markers);
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
